// ----- hw/rtl/fjot_pkg.sv -----
// Shared types and constants for the flat JSON object tokenizer.
package fjot_pkg;

    typedef enum logic [3:0] {
        PH_OPEN       = 4'd0,
        PH_AFTER_OPEN = 4'd1,
        PH_COMMA      = 4'd2,
        PH_COMMA_WS   = 4'd3,
        PH_STRING     = 4'd4,
        PH_COLON      = 4'd5,
        PH_VALUE      = 4'd6,
        PH_SIGN       = 4'd7,
        PH_DIGITS     = 4'd8,
        PH_AFTER_VAL  = 4'd9,
        PH_TRAIL      = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        TK_KEY_BYTE = 3'd0,
        TK_KEY_END  = 3'd1,
        TK_STR_BYTE = 3'd2,
        TK_STR_END  = 3'd3,
        TK_INT      = 3'd4,
        TK_OK       = 3'd5,
        TK_ERR      = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ER_NO_BRACE   = 4'd0,
        ER_NO_STRING  = 4'd1,
        ER_INC_ESCAPE = 4'd2,
        ER_BAD_ESCAPE = 4'd3,
        ER_UNTERM     = 4'd4,
        ER_NO_COLON   = 4'd5,
        ER_NO_VALUE   = 4'd6,
        ER_NO_INT     = 4'd7,
        ER_RANGE      = 4'd8,
        ER_EARLY_END  = 4'd9,
        ER_TRAILING   = 4'd10,
        ER_NO_COMMA   = 4'd11
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         ch;
        logic signed [31:0] val;
        err_t               code;
        logic               last;
    } token_t;

    typedef struct packed {
        logic [1:0] cnt;
        token_t     t0;
        token_t     t1;
    } step_t;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam int QDEPTH = 4;
    localparam int CW     = $clog2(QDEPTH + 1);

endpackage

// ----- hw/rtl/flat_json_object_tokenizer.sv -----
// Top level of the flat JSON object tokenizer: byte input, token output.
//
// The text channel (text_valid, text_ready, text_byte, end_of_text) takes one
// document byte per transfer; end_of_text marks the final byte of a document.
// The token channel (token_valid, token_ready and the token fields) delivers
// key and string bytes, string end markers, integers, and one closing status
// per document: document ok or an error with its code. last_of_run is set on
// the final token caused by a byte. After an error, the rest of the document
// produces nothing until its final byte, which rearms the parser.
// A byte is parsed in the cycle it is accepted; its first token is queued on
// the next cycle. One byte is accepted every cycle while the result queue
// holds two tokens or fewer, so the rate is one byte per cycle while each
// byte yields at most one token; a byte that yields two tokens hands them out
// one at a time through the single token output port.
// When the receiver stalls, tokens collect in a four-entry queue and
// text_ready drops once more than two are waiting.
// Reset clears the parser to wait for an opening brace and empties the queue.
module flat_json_object_tokenizer
    import fjot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output logic               token_valid,
    input  logic               token_ready,
    output logic [2:0]         token_kind,
    output logic [7:0]         char_out,
    output logic signed [31:0] int_out,
    output logic [3:0]         error_code,
    output logic               last_of_run
);

    logic       fire;
    logic       room;
    step_t      step;
    logic [1:0] push_cnt;
    token_t     head;

    assign fire     = text_valid && text_ready;
    assign push_cnt = fire ? step.cnt : 2'd0;

    fjot_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .step        (step)
    );

    fjot_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push0       (step.t0),
        .push1       (step.t1),
        .room        (room),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .head        (head)
    );

    assign text_ready  = room;
    assign token_kind  = head.kind;
    assign char_out    = head.ch;
    assign int_out     = head.val;
    assign error_code  = head.code;
    assign last_of_run = head.last;

endmodule

// ----- hw/rtl/fjot_core.sv -----
// Parser state registers and the per-byte next-state and token logic.
module fjot_core
    import fjot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output step_t      step
);

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic        key_reg, key_next;
    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        failed_reg, failed_next;

    token_t      tok [2];
    logic [1:0]  cnt;
    logic        is_ws;
    logic        is_dig;
    logic        cont;
    logic [35:0] prod;
    logic        prod_ovf;
    logic [7:0]  esc_char;
    logic        esc_ok;
    kind_t       byte_kind;

    function automatic token_t mk(kind_t k, logic [7:0] c, logic [31:0] v, err_t e);
        token_t t;
        t.kind = k;
        t.ch   = c;
        t.val  = v;
        t.code = e;
        t.last = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        is_ws    = (text_byte == CH_SPACE) || (text_byte inside {[CH_TAB:CH_CR]});
        is_dig   = text_byte inside {[CH_ZERO:CH_NINE]};
        prod     = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                   + {32'b0, text_byte[3:0]};
        prod_ovf = ovf_reg || (prod > 36'h080000000);
        byte_kind = key_reg ? TK_KEY_BYTE : TK_STR_BYTE;
        esc_ok   = 1'b1;
        case (text_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_char = text_byte;
            CH_B:    esc_char = CH_BS;
            CH_F:    esc_char = CH_FF;
            CH_N:    esc_char = CH_LF;
            CH_R:    esc_char = CH_CR;
            CH_T:    esc_char = CH_TAB;
            default:
            begin
                esc_char = 8'h00;
                esc_ok   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        key_next    = key_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;
        failed_next = failed_reg;
        tok[0]      = mk(TK_KEY_BYTE, 8'h00, 32'h0, ER_NO_BRACE);
        tok[1]      = mk(TK_KEY_BYTE, 8'h00, 32'h0, ER_NO_BRACE);
        cnt         = 2'd0;
        cont        = 1'b1;

        if (!failed_reg)
        begin
            if (phase_reg == PH_DIGITS)
            begin
                cont = 1'b0;
                if (is_dig)
                begin
                    if (prod_ovf)
                        ovf_next = 1'b1;
                    else
                        mag_next = prod[31:0];
                end
                else if (ovf_reg || (!neg_reg && mag_reg[31]))
                begin
                    tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_RANGE);
                    cnt = cnt + 2'd1;
                    failed_next = 1'b1;
                end
                else
                begin
                    tok[cnt[0]] = mk(TK_INT, 8'h00,
                                     neg_reg ? (32'd0 - mag_reg) : mag_reg, ER_NO_BRACE);
                    cnt = cnt + 2'd1;
                    phase_next = PH_AFTER_VAL;
                    cont = 1'b1;
                end
            end

            if (cont)
            begin
                case (phase_next)
                    PH_AFTER_OPEN:
                    begin
                        if (!is_ws)
                        begin
                            if (text_byte == CH_RBRACE)
                                phase_next = PH_TRAIL;
                            else if (text_byte == CH_QUOTE)
                            begin
                                key_next   = 1'b1;
                                esc_next   = 1'b0;
                                phase_next = PH_STRING;
                            end
                            else
                            begin
                                tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_STRING);
                                cnt = cnt + 2'd1;
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_COMMA, PH_COMMA_WS:
                    begin
                        if (is_ws)
                            phase_next = PH_COMMA_WS;
                        else if (text_byte == CH_QUOTE)
                        begin
                            key_next   = 1'b1;
                            esc_next   = 1'b0;
                            phase_next = PH_STRING;
                        end
                        else
                        begin
                            tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_STRING);
                            cnt = cnt + 2'd1;
                            failed_next = 1'b1;
                        end
                    end
                    PH_STRING:
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            if (esc_ok)
                                tok[cnt[0]] = mk(byte_kind, esc_char, 32'h0, ER_NO_BRACE);
                            else
                            begin
                                tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_BAD_ESCAPE);
                                failed_next = 1'b1;
                            end
                            cnt = cnt + 2'd1;
                        end
                        else if (text_byte == CH_QUOTE)
                        begin
                            tok[cnt[0]] = mk(key_reg ? TK_KEY_END : TK_STR_END, 8'h00,
                                             32'h0, ER_NO_BRACE);
                            cnt = cnt + 2'd1;
                            phase_next = key_reg ? PH_COLON : PH_AFTER_VAL;
                        end
                        else if (text_byte == CH_BSLASH)
                            esc_next = 1'b1;
                        else
                        begin
                            tok[cnt[0]] = mk(byte_kind, text_byte, 32'h0, ER_NO_BRACE);
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_COLON:
                    begin
                        if (!is_ws)
                        begin
                            if (text_byte == CH_COLON)
                                phase_next = PH_VALUE;
                            else
                            begin
                                tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_COLON);
                                cnt = cnt + 2'd1;
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        if (!is_ws)
                        begin
                            if (text_byte == CH_QUOTE)
                            begin
                                key_next   = 1'b0;
                                esc_next   = 1'b0;
                                phase_next = PH_STRING;
                            end
                            else if (text_byte == CH_MINUS)
                            begin
                                neg_next   = 1'b1;
                                mag_next   = 32'd0;
                                ovf_next   = 1'b0;
                                phase_next = PH_SIGN;
                            end
                            else if (is_dig)
                            begin
                                neg_next   = 1'b0;
                                mag_next   = {28'd0, text_byte[3:0]};
                                ovf_next   = 1'b0;
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_INT);
                                cnt = cnt + 2'd1;
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_dig)
                        begin
                            if (prod_ovf)
                                ovf_next = 1'b1;
                            else
                                mag_next = prod[31:0];
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_INT);
                            cnt = cnt + 2'd1;
                            failed_next = 1'b1;
                        end
                    end
                    PH_AFTER_VAL:
                    begin
                        if (!is_ws)
                        begin
                            if (text_byte == CH_RBRACE)
                                phase_next = PH_TRAIL;
                            else if (text_byte == CH_COMMA)
                                phase_next = PH_COMMA;
                            else
                            begin
                                tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_COMMA);
                                cnt = cnt + 2'd1;
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (!is_ws)
                        begin
                            tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_TRAILING);
                            cnt = cnt + 2'd1;
                            failed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!is_ws)
                        begin
                            if (text_byte == CH_LBRACE)
                                phase_next = PH_AFTER_OPEN;
                            else
                            begin
                                tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_BRACE);
                                cnt = cnt + 2'd1;
                                failed_next = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        if (end_of_text)
        begin
            if (!failed_next)
            begin
                case (phase_next)
                    PH_TRAIL:
                        tok[cnt[0]] = mk(TK_OK, 8'h00, 32'h0, ER_NO_BRACE);
                    PH_AFTER_OPEN, PH_COMMA, PH_AFTER_VAL:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_EARLY_END);
                    PH_COMMA_WS:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_STRING);
                    PH_STRING:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0,
                                         esc_next ? ER_INC_ESCAPE : ER_UNTERM);
                    PH_COLON:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_COLON);
                    PH_VALUE:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_VALUE);
                    PH_SIGN:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_INT);
                    PH_DIGITS:
                    begin
                        if (ovf_next || (!neg_next && mag_next[31]))
                            tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_RANGE);
                        else
                        begin
                            tok[cnt[0]] = mk(TK_INT, 8'h00,
                                             neg_next ? (32'd0 - mag_next) : mag_next,
                                             ER_NO_BRACE);
                            cnt = cnt + 2'd1;
                            tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_EARLY_END);
                        end
                    end
                    default:
                        tok[cnt[0]] = mk(TK_ERR, 8'h00, 32'h0, ER_NO_BRACE);
                endcase
                cnt = cnt + 2'd1;
            end
            phase_next  = PH_OPEN;
            esc_next    = 1'b0;
            key_next    = 1'b0;
            mag_next    = 32'd0;
            neg_next    = 1'b0;
            ovf_next    = 1'b0;
            failed_next = 1'b0;
        end

        if (cnt == 2'd1)
            tok[0].last = 1'b1;
        else if (cnt == 2'd2)
            tok[1].last = 1'b1;

        step.cnt = cnt;
        step.t0  = tok[0];
        step.t1  = tok[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            esc_reg    <= 1'b0;
            key_reg    <= 1'b0;
            mag_reg    <= 32'd0;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            failed_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            key_reg    <= key_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            ovf_reg    <= ovf_next;
            failed_reg <= failed_next;
        end
    end

    // A latched error silences every byte up to the end of the document.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && failed_reg && !end_of_text |-> step.cnt == 2'd0)
        else $error("tokens produced after a latched error");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_text |=> phase_reg == PH_OPEN && !failed_reg && !esc_reg)
        else $error("end of document did not restore the initial state");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_text && !failed_reg |-> step.cnt != 2'd0)
        else $error("end of document produced no status token");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (step.cnt == 2'd2) |-> step.t1.last && !step.t0.last)
        else $error("last marker misplaced on a two-token byte");

endmodule

// ----- hw/rtl/fjot_queue.sv -----
// Shifting result queue that takes up to two tokens per cycle and presents one.
module fjot_queue
    import fjot_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  token_t              push0,
    input  token_t              push1,
    output logic                room,
    output logic                token_valid,
    input  logic                token_ready,
    output token_t              head
);

    token_t        q_reg [QDEPTH];
    token_t        q_next [QDEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] base;
    logic          pop;

    always_comb
    begin
        pop  = (count_reg != '0) && token_ready;
        base = count_reg - {{(CW-1){1'b0}}, pop};
        for (int i = 0; i < QDEPTH - 1; i++)
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        q_next[QDEPTH - 1] = q_reg[QDEPTH - 1];
        for (int i = 0; i < QDEPTH; i++)
        begin
            if ((push_cnt != 2'd0) && (CW'(i) == base))
                q_next[i] = push0;
            else if ((push_cnt == 2'd2) && (CW'(i) == base + CW'(1)))
                q_next[i] = push1;
        end
        count_next = base + CW'(push_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    assign room        = count_reg <= CW'(QDEPTH - 2);
    assign token_valid = count_reg != '0;
    assign head        = q_reg[0];

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QDEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> room)
        else $error("tokens pushed without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_ready && push_cnt == 2'd0 |=>
            count_reg == $past(count_reg) - CW'(1))
        else $error("queue count wrong after a transfer out");

endmodule
